>>> sv/tcw_pkg.sv
package tcw_pkg;

    // Operation codes carried in s_tuser.
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_DEC  = 2'd1;
    localparam logic [1:0] OP_HEX  = 2'd2;

    // Character codes with special meaning or used as fixed text.
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_MINUS     = 8'h2D;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;

    // Widths of the number path.
    localparam int BIN_W      = 32;
    localparam int DEC_DIGITS = 10;
    localparam int HEX_DIGITS = 8;
    localparam int BCD_W      = 4 * DEC_DIGITS;
    localparam int ITER_W     = $clog2(BIN_W);
    localparam int CELL_ADDR_W = 11;

    // Cursor movement requested by the sequencer.
    typedef enum logic [1:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_BACK
    } cursor_cmd_t;

    // Status of the binary to BCD converter.
    typedef struct packed {
        logic               busy;
        logic [BCD_W-1:0]   bcd;
    } bcd_status_t;

    // Maps one nibble to its uppercase hex character.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] code;
        if (nib < 4'd10) begin
            code = CHAR_ZERO + {4'd0, nib};
        end else begin
            code = CHAR_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return code;
    endfunction

endpackage

>>> sv/text_console_cell_writer_top.sv
// A character is accepted, then written to its cell. A hex value is accepted, then
// written cell by cell; a decimal value is accepted, goes through the
// shift-and-add-three conversion, drops leading zeros, then is written cell by
// cell (up to 11 cells). Input is taken only between items.
// Output stalls hold the sequencer. Synchronous active-low reset puts the cursor
// at the top left and empties the output register.
module text_console_cell_writer_top #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // character [7:0], value [39:8], color [47:40]
    input  logic [1:0]  s_tuser,   // op [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cell_address [10:0], cell_value [26:11], zero above
    output logic        m_tlast
);

    localparam int SCREEN_W = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);
    localparam int ADDR_W   = (SCREEN_W > tcw_pkg::CELL_ADDR_W) ?
                              SCREEN_W : tcw_pkg::CELL_ADDR_W;
    localparam int DCNT_W   = $clog2(tcw_pkg::DEC_DIGITS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                     state_reg,   state_next;
    logic [7:0]                 char_reg,    char_next;
    logic [7:0]                 color_reg,   color_next;
    logic                       back_reg,    back_next;
    logic [15:0]                pre_reg,     pre_next;
    logic [1:0]                 pre_cnt_reg, pre_cnt_next;
    logic [tcw_pkg::BCD_W-1:0]  dig_reg,     dig_next;
    logic [DCNT_W-1:0]          dig_cnt_reg, dig_cnt_next;
    logic                       m_valid_reg, m_valid_next;
    logic [10:0]                m_addr_reg,  m_addr_next;
    logic [15:0]                m_value_reg, m_value_next;
    logic                       m_last_reg,  m_last_next;

    logic                       in_xfer;
    logic                       out_free;
    logic [1:0]                 in_op;
    logic [7:0]                 in_char;
    logic [31:0]                in_value;
    logic [7:0]                 in_color;
    logic                       in_neg;
    logic [31:0]                in_mag;
    logic                       bcd_start;
    tcw_pkg::bcd_status_t       bcd_status;
    tcw_pkg::cursor_cmd_t       cur_cmd;
    logic [ADDR_W-1:0]          cur_addr;

    assign in_char  = s_tdata[7:0];
    assign in_value = s_tdata[39:8];
    assign in_color = s_tdata[47:40];
    assign in_op    = s_tuser;
    assign in_neg   = in_value[31];
    assign in_mag   = in_neg ? (~in_value + 32'd1) : in_value;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    tcw_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS),
        .ADDR_W         (ADDR_W)
    ) u_cursor (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cur_cmd),
        .addr    (cur_addr)
    );

    tcw_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .mag     (in_mag),
        .status  (bcd_status)
    );

    // Sequencer: takes one item, then walks its characters one cell per cycle while the output is not stalled.
    always_comb begin
        state_next   = state_reg;
        char_next    = char_reg;
        color_next   = color_reg;
        back_next    = back_reg;
        pre_next     = pre_reg;
        pre_cnt_next = pre_cnt_reg;
        dig_next     = dig_reg;
        dig_cnt_next = dig_cnt_reg;
        m_valid_next = m_valid_reg;
        m_addr_next  = m_addr_reg;
        m_value_next = m_value_reg;
        m_last_next  = m_last_reg;
        bcd_start    = 1'b0;
        cur_cmd      = tcw_pkg::CUR_HOLD;

        // The downstream side took the pending transfer.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    char_next  = in_char;
                    color_next = in_color;
                    back_next  = (in_char == tcw_pkg::CHAR_BACKSPACE);
                    priority if (in_op == tcw_pkg::OP_CHAR) begin
                        if (in_char == tcw_pkg::CHAR_NEWLINE) begin
                            cur_cmd = tcw_pkg::CUR_NEWLINE;
                        end else begin
                            if (in_char == tcw_pkg::CHAR_BACKSPACE) begin
                                cur_cmd = tcw_pkg::CUR_BACK;
                            end
                            state_next = ST_CHAR;
                        end
                    end else if (in_op == tcw_pkg::OP_DEC) begin
                        bcd_start    = 1'b1;
                        pre_next     = {tcw_pkg::CHAR_MINUS, 8'd0};
                        pre_cnt_next = in_neg ? 2'd1 : 2'd0;
                        dig_cnt_next = DCNT_W'(tcw_pkg::DEC_DIGITS);
                        state_next   = ST_CONV;
                    end else if (in_op == tcw_pkg::OP_HEX) begin
                        pre_next     = {tcw_pkg::CHAR_ZERO, tcw_pkg::CHAR_LOWER_X};
                        pre_cnt_next = 2'd2;
                        dig_next     = {in_value, 8'd0};
                        dig_cnt_next = DCNT_W'(tcw_pkg::HEX_DIGITS);
                        state_next   = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CHAR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = cur_addr[10:0];
                    m_value_next = {color_reg, back_reg ? tcw_pkg::CHAR_SPACE : char_reg};
                    m_last_next  = 1'b1;
                    cur_cmd      = back_reg ? tcw_pkg::CUR_HOLD : tcw_pkg::CUR_ADVANCE;
                    state_next   = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (!bcd_status.busy) begin
                    dig_next   = bcd_status.bcd;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zero digits, keeping at least one.
                if ((dig_cnt_reg > DCNT_W'(1)) &&
                    (dig_reg[tcw_pkg::BCD_W-1 -: 4] == 4'd0)) begin
                    dig_next     = {dig_reg[tcw_pkg::BCD_W-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = cur_addr[10:0];
                    cur_cmd      = tcw_pkg::CUR_ADVANCE;
                    if (pre_cnt_reg != 2'd0) begin
                        m_value_next = {color_reg, pre_reg[15:8]};
                        m_last_next  = 1'b0;
                        pre_next     = {pre_reg[7:0], 8'd0};
                        pre_cnt_next = pre_cnt_reg - 1'b1;
                    end else begin
                        m_value_next = {color_reg,
                                        tcw_pkg::hex_char(dig_reg[tcw_pkg::BCD_W-1 -: 4])};
                        m_last_next  = (dig_cnt_reg == DCNT_W'(1));
                        dig_next     = {dig_reg[tcw_pkg::BCD_W-5:0], 4'd0};
                        dig_cnt_next = dig_cnt_reg - 1'b1;
                        if (dig_cnt_reg == DCNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg    <= char_next;
        color_reg   <= color_next;
        back_reg    <= back_next;
        pre_reg     <= pre_next;
        pre_cnt_reg <= pre_cnt_next;
        dig_reg     <= dig_next;
        dig_cnt_reg <= dig_cnt_next;
        m_addr_reg  <= m_addr_next;
        m_value_reg <= m_value_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_value_reg, m_addr_reg};
    assign m_tlast  = m_last_reg;

endmodule

>>> sv/tcw_cursor.sv
module tcw_cursor #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int ADDR_W         = 11
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  tcw_pkg::cursor_cmd_t  cmd,
    output logic [ADDR_W-1:0]     addr
);

    localparam int COL_W = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;

    logic [COL_W-1:0]  col_reg,  col_next;
    logic [ROW_W-1:0]  row_reg,  row_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic              at_last_col;
    logic              at_last_row;

    assign at_last_col = (col_reg == COL_W'(SCREEN_COLUMNS - 1));
    assign at_last_row = (row_reg == ROW_W'(SCREEN_ROWS - 1));

    // The row base tracks row times columns, so the address needs one add.
    assign addr = base_reg + ADDR_W'(col_reg);

    // Cursor movement.
    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        base_next = base_reg;
        unique case (cmd)
            tcw_pkg::CUR_HOLD: begin
            end
            tcw_pkg::CUR_ADVANCE: begin
                if (at_last_col) begin
                    col_next = '0;
                    if (at_last_row) begin
                        row_next  = '0;
                        base_next = '0;
                    end else begin
                        row_next  = row_reg + 1'b1;
                        base_next = base_reg + ADDR_W'(SCREEN_COLUMNS);
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            tcw_pkg::CUR_NEWLINE: begin
                col_next = '0;
                if (at_last_row) begin
                    row_next  = '0;
                    base_next = '0;
                end else begin
                    row_next  = row_reg + 1'b1;
                    base_next = base_reg + ADDR_W'(SCREEN_COLUMNS);
                end
            end
            tcw_pkg::CUR_BACK: begin
                if (col_reg != '0) begin
                    col_next = col_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            base_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            base_reg <= base_next;
        end
    end

endmodule

>>> sv/tcw_bcd.sv
module tcw_bcd (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tcw_pkg::BIN_W-1:0]     mag,
    output tcw_pkg::bcd_status_t          status
);

    logic [tcw_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic [tcw_pkg::BIN_W-1:0]  bin_reg, bin_next;
    logic [tcw_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic                       busy_reg, busy_next;
    logic [tcw_pkg::BCD_W-1:0]  adj;

    // Add three to every digit of five or more before the shift.
    always_comb begin
        for (int k = 0; k < tcw_pkg::DEC_DIGITS; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5) begin
                adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
            end else begin
                adj[4*k +: 4] = bcd_reg[4*k +: 4];
            end
        end
    end

    // One bit of the magnitude enters the digit register per cycle while the conversion is busy.
    always_comb begin
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        iter_next = iter_reg;
        busy_next = busy_reg;
        if (start) begin
            bcd_next  = '0;
            bin_next  = mag;
            iter_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bcd_next  = {adj[tcw_pkg::BCD_W-2:0], bin_reg[tcw_pkg::BIN_W-1]};
            bin_next  = {bin_reg[tcw_pkg::BIN_W-2:0], 1'b0};
            iter_next = iter_reg + 1'b1;
            if (iter_reg == {tcw_pkg::ITER_W{1'b1}}) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign status.busy = busy_reg;
    assign status.bcd  = bcd_reg;

endmodule

>>> sim/text_console_cell_writer_top_tb.sv
`timescale 1ns / 100ps

module text_console_cell_writer_top_tb;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int RANDOM_ITEMS = 360;
    // Worst decimal item: accept, conversion, zero strip and eleven cell writes.
    localparam int DRAIN_CYCLES = 64;

    // The fourth op code has no meaning; the block must drop it silently.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Expected screen activity: tracks the cursor and holds the cell writes
    // that each accepted item should cause, oldest first.
    class console_screen_model;
        typedef struct packed {
            logic [10:0] addr;
            logic [15:0] value;
            logic        last;
        } cell_write_t;

        cell_write_t pending_cells[$];
        int unsigned column;
        int unsigned row;
        int unsigned errors;
        string       hex_map;

        function new();
            column  = 0;
            row     = 0;
            errors  = 0;
            hex_map = "0123456789ABCDEF";
        endfunction

        function void next_row();
            column = 0;
            row++;
            if (row >= ROWS) begin
                row = 0;
            end
        endfunction

        function void advance();
            column++;
            if (column >= COLUMNS) begin
                next_row();
            end
        endfunction

        function void push_cell(logic [7:0] ch, logic [7:0] color, logic last);
            cell_write_t entry;
            entry.addr  = 11'(row * COLUMNS + column);
            entry.value = {color, ch};
            entry.last  = last;
            pending_cells.push_back(entry);
        endfunction

        // Works out the cell writes caused by one accepted input transfer.
        function void note_item(logic [1:0] op, logic [7:0] ch, logic [31:0] val,
                                logic [7:0] color);
            logic [7:0]  text[$];
            logic [7:0]  digits[$];
            logic [31:0] mag;
            unique case (op)
                tcw_pkg::OP_CHAR: begin
                    if (ch == tcw_pkg::CHAR_NEWLINE) begin
                        next_row();
                    end else if (ch == tcw_pkg::CHAR_BACKSPACE) begin
                        // Step left unless at the margin, then blank that cell.
                        if (column > 0) begin
                            column--;
                        end
                        push_cell(tcw_pkg::CHAR_SPACE, color, 1'b1);
                    end else begin
                        push_cell(ch, color, 1'b1);
                        advance();
                    end
                end
                tcw_pkg::OP_DEC, tcw_pkg::OP_HEX: begin
                    if (op == tcw_pkg::OP_DEC) begin
                        mag = val;
                        if (val[31]) begin
                            text.push_back(tcw_pkg::CHAR_MINUS);
                            mag = ~val + 32'd1;
                        end
                        do begin
                            digits.push_front(tcw_pkg::CHAR_ZERO + 8'(mag % 10));
                            mag = mag / 10;
                        end while (mag != 0);
                        foreach (digits[i]) begin
                            text.push_back(digits[i]);
                        end
                    end else begin
                        text.push_back(tcw_pkg::CHAR_ZERO);
                        text.push_back(tcw_pkg::CHAR_LOWER_X);
                        for (int sh = 28; sh >= 0; sh -= 4) begin
                            text.push_back(hex_map[(val >> sh) & 32'hF]);
                        end
                    end
                    foreach (text[i]) begin
                        push_cell(text[i], color, i == text.size() - 1);
                        advance();
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compares one output transfer with the oldest expected cell write.
        function void check_cell(logic [10:0] addr, logic [15:0] value, logic last);
            cell_write_t exp;
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected cell write, expected none, actual addr %0d value %h",
                         $time, addr, value);
                errors++;
                return;
            end
            exp = pending_cells.pop_front();
            if (addr !== exp.addr) begin
                $display("%0t: cell_address expected %0d, actual %0d", $time, exp.addr, addr);
                errors++;
            end
            if (value !== exp.value) begin
                $display("%0t: cell_value expected %h, actual %h", $time, exp.value, value);
                errors++;
            end
            if (last !== exp.last) begin
                $display("%0t: last expected %b, actual %b", $time, exp.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_cells.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Set during stretches in which neither side idles.
    logic        no_idle  = 1'b0;

    console_screen_model screen;

    text_console_cell_writer_top #(
        .SCREEN_COLUMNS(COLUMNS),
        .SCREEN_ROWS   (ROWS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    // Offers one item after a random gap and waits for its transfer.
    task automatic send_item(logic [1:0] op, logic [7:0] ch, logic [31:0] val,
                             logic [7:0] color);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {color, val, ch};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        screen.note_item(op, ch, val, color);
    endtask

    // Holds the input side until every expected cell write has come out.
    task automatic wait_for_screen();
        s_tvalid <= 1'b0;
        while (screen.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Values skewed toward the interesting corners of both print formats.
    function automatic logic [31:0] pick_value();
        logic [31:0] corners[8] = '{32'h0, 32'h1, 32'h7FFFFFFF, 32'h80000000,
                                    32'hFFFFFFFF, 32'h80000001, 32'd999999999,
                                    32'd1000000000};
        unique case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1: return -$urandom_range(1, 99);
            2: return corners[$urandom_range(0, 7)];
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random stalls, then one transfer checked per loop.
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            screen.check_cell(m_tdata[10:0], m_tdata[26:11], m_tlast);
        end
    end

    // Stimulus: directed corners, then random items in phases.
    initial begin
        int          sent;
        int          pick;
        logic [1:0]  op;
        logic [7:0]  ch;
        screen = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(tcw_pkg::OP_CHAR, 8'h41, 32'h0, 8'h00);
        send_item(tcw_pkg::OP_CHAR, 8'hFF, 32'hFFFFFFFF, 8'hFF);
        send_item(tcw_pkg::OP_CHAR, 8'h00, 32'h12345678, 8'h5A);
        send_item(tcw_pkg::OP_CHAR, tcw_pkg::CHAR_BACKSPACE, 32'h0, 8'h17);
        send_item(tcw_pkg::OP_CHAR, tcw_pkg::CHAR_NEWLINE, 32'h0, 8'h17);
        // Backspace at the left margin stays there and writes a blank.
        send_item(tcw_pkg::OP_CHAR, tcw_pkg::CHAR_BACKSPACE, 32'h0, 8'h71);
        send_item(tcw_pkg::OP_CHAR, tcw_pkg::CHAR_SPACE, 32'h0, 8'hA5);
        send_item(tcw_pkg::OP_DEC, 8'hFF, 32'd0, 8'h1F);
        send_item(tcw_pkg::OP_DEC, 8'h00, 32'hFFFFFFFF, 8'h2E);
        send_item(tcw_pkg::OP_DEC, 8'h0A, 32'h80000000, 8'h3D);
        send_item(tcw_pkg::OP_DEC, 8'h08, 32'h7FFFFFFF, 8'h4C);
        send_item(tcw_pkg::OP_DEC, 8'h00, 32'd1234567890, 8'h5B);
        send_item(tcw_pkg::OP_DEC, 8'h00, 32'd9, 8'h6A);
        send_item(tcw_pkg::OP_DEC, 8'h00, 32'd10, 8'h79);
        send_item(tcw_pkg::OP_HEX, 8'h00, 32'h0, 8'h88);
        send_item(tcw_pkg::OP_HEX, 8'hFF, 32'hFFFFFFFF, 8'h97);
        send_item(tcw_pkg::OP_HEX, 8'h0A, 32'h89ABCDEF, 8'hE6);
        send_item(OP_UNUSED, 8'h41, 32'hFFFFFFFF, 8'hFF);
        send_item(tcw_pkg::OP_CHAR, tcw_pkg::CHAR_NEWLINE, 32'h0, 8'h00);
        wait_for_screen();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent % 60 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (sent > 0 && sent % 90 == 0) begin
                wait_for_screen();
            end
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom);
            if (pick < 40) begin
                op = tcw_pkg::OP_CHAR;
                if (pick < 7) begin
                    ch = tcw_pkg::CHAR_NEWLINE;
                end else if (pick < 11) begin
                    ch = tcw_pkg::CHAR_BACKSPACE;
                end
            end else if (pick < 68) begin
                op = tcw_pkg::OP_DEC;
            end else if (pick < 95) begin
                op = tcw_pkg::OP_HEX;
            end else begin
                op = OP_UNUSED;
            end
            send_item(op, ch, pick_value(), 8'($urandom));
            if (op != OP_UNUSED) begin
                sent++;
            end
        end

        // Let every cell write come out, then watch for strays.
        s_tvalid <= 1'b0;
        while (screen.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (screen.errors == 0 && screen.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
